@@ rtl/wwcg_pkg.sv @@
`default_nettype none

package wwcg_pkg;

    // Default sizing
    localparam int MAX_LEN_DEF  = 4096;
    localparam int WAKE_MAX_DEF = 8;
    localparam int QUEUE_DEPTH  = 2;

    // Register field widths
    localparam int WAKE_CHARS_W = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 64;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MUTE       = 2'd0,
        CFG_WAKE_CHARS = 2'd1,
        CFG_WAKE_LEN   = 2'd2,
        CFG_MIN_VOICE  = 2'd3
    } t_cfg_idx;

    // Verdict codes
    typedef enum logic [2:0] {
        RC_ACCEPTED     = 3'd0,
        RC_MUTED        = 3'd1,
        RC_EMPTY        = 3'd2,
        RC_LOW_VOICE    = 3'd3,
        RC_WAKE_MISSING = 3'd4,
        RC_NO_COMMAND   = 3'd5
    } t_result_code;

    // Run state codes
    typedef enum logic [1:0] {
        RUN_IDLE    = 2'd0,
        RUN_MUTED   = 2'd1,
        RUN_SENDING = 2'd2
    } t_run_state;

    localparam logic [11:0] OFFSET_SAT = 12'hFFF;
    localparam logic [12:0] LEN_SAT    = 13'h1FFF;

    // Byte class handed from the front end to the back end
    typedef struct packed {
        logic nul;
        logic last;
        logic space;
        logic alnum;
    } t_cls;

    // One verdict word
    typedef struct packed {
        t_result_code result_code;
        logic         send_ok;
        logic [11:0]  command_offset;
        logic [12:0]  cmd_len;
        t_run_state   run_state;
        logic         too_long;
    } t_verdict;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

`default_nettype wire

@@ rtl/wwcg_fifo.sv @@
`default_nettype none

module wwcg_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr,
    input  wire logic [W-1:0] i_wdata,
    output logic              o_full,
    input  wire logic         i_rd,
    output logic [W-1:0]      o_rdata,
    output logic              o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr_en;
    logic          rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    // Store incoming word
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (rd_en) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/wwcg_front.sv @@
`default_nettype none

module wwcg_front #(
    parameter int WAKE_MAX = 8
) (
    input  wire logic [7:0]                   i_ch,
    input  wire logic                         i_last,
    input  wire logic [wwcg_pkg::WAKE_CHARS_W-1:0] i_wake_chars,
    output wwcg_pkg::t_cls                    o_cls,
    output logic [WAKE_MAX-1:0]               o_match
);
    import wwcg_pkg::*;

    logic [7:0] ch_lc;

    assign ch_lc = to_lower(i_ch);

    // Classify the byte
    always_comb begin
        o_cls.nul   = (i_ch == 8'd0);
        o_cls.last  = i_last;
        o_cls.space = is_space(i_ch);
        o_cls.alnum = is_alnum(i_ch);
    end

    // Compare against every wake word character at once
    always_comb begin
        for (int k = 0; k < WAKE_MAX; k++) begin
            o_match[k] = (ch_lc == to_lower(i_wake_chars[8*k +: 8]));
        end
    end

endmodule

`default_nettype wire

@@ rtl/wwcg_back.sv @@
`default_nettype none

module wwcg_back #(
    parameter int MAX_LEN  = 4096,
    parameter int WAKE_MAX = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_mute,
    input  wire logic [3:0]          i_wake_len,
    input  wire logic [7:0]          i_min_voice,
    input  wire logic                i_in_empty,
    input  wwcg_pkg::t_cls           i_cls,
    input  wire logic [WAKE_MAX-1:0] i_match,
    output logic                     o_pop,
    input  wire logic                i_out_full,
    output logic                     o_push,
    output wwcg_pkg::t_verdict       o_verdict
);
    import wwcg_pkg::*;

    localparam int PB_W  = $clog2(MAX_LEN + 1);
    localparam int POS_W = $clog2(MAX_LEN);

    logic [PB_W-1:0]  r_pos,       n_pos;
    logic             r_seen,      n_seen;
    logic [3:0]       r_wake_idx,  n_wake_idx;
    logic             r_failed,    n_failed;
    logic [7:0]       r_alnum,     n_alnum;
    logic             r_cmd_seen,  n_cmd_seen;
    logic [POS_W-1:0] r_cmd_start, n_cmd_start;
    logic [POS_W-1:0] r_last_ns,   n_last_ns;
    logic             r_ended,     n_ended;
    logic             r_over,      n_over;

    logic [3:0]       wl;
    logic             wmatch;
    logic [POS_W:0]   len_full;
    logic [31:0]      off_ext;
    logic [31:0]      len_ext;

    // Take a byte unless a stalled verdict blocks it
    assign o_pop  = !i_in_empty && (!i_cls.last || !i_out_full);
    assign o_push = o_pop && i_cls.last;

    assign wl = (i_wake_len > 4'(WAKE_MAX)) ? 4'(WAKE_MAX) : i_wake_len;

    // Pick the match bit for the current wake word character
    always_comb begin
        wmatch = 1'b0;
        for (int k = 0; k < WAKE_MAX; k++) begin
            if (r_wake_idx == 4'(k)) begin
                wmatch = i_match[k];
            end
        end
    end

    // Per-byte state update
    always_comb begin
        n_pos       = r_pos;
        n_seen      = r_seen;
        n_wake_idx  = r_wake_idx;
        n_failed    = r_failed;
        n_alnum     = r_alnum;
        n_cmd_seen  = r_cmd_seen;
        n_cmd_start = r_cmd_start;
        n_last_ns   = r_last_ns;
        n_ended     = r_ended;
        n_over      = r_over;
        if (o_pop && !r_ended) begin
            if (i_cls.nul) begin
                n_ended = 1'b1;
            end else if (r_pos == PB_W'(MAX_LEN)) begin
                n_over = 1'b1;
            end else begin
                n_pos = r_pos + PB_W'(1);
                // Skip leading whitespace
                if (r_seen || !i_cls.space) begin
                    n_seen = 1'b1;
                    if (i_cls.alnum && r_alnum != 8'hFF) begin
                        n_alnum = r_alnum + 8'd1;
                    end
                    if (!i_cls.space) begin
                        n_last_ns = r_pos[POS_W-1:0];
                    end
                    if (wl != 4'd0 && !r_failed) begin
                        if (r_wake_idx < wl) begin
                            if (wmatch) begin
                                n_wake_idx = r_wake_idx + 4'd1;
                            end else begin
                                n_failed = 1'b1;
                            end
                        end else if (!r_cmd_seen && !i_cls.space) begin
                            n_cmd_seen  = 1'b1;
                            n_cmd_start = r_pos[POS_W-1:0];
                        end
                    end
                end
            end
        end
    end

    assign len_full = (POS_W+1)'(n_last_ns) - (POS_W+1)'(n_cmd_start) + (POS_W+1)'(1);
    assign off_ext  = 32'(n_cmd_start);
    assign len_ext  = 32'(len_full);

    // Build the verdict from the state after this byte
    always_comb begin
        o_verdict             = '0;
        o_verdict.result_code = RC_ACCEPTED;
        o_verdict.run_state   = RUN_IDLE;
        o_verdict.too_long    = n_over;
        if (i_mute) begin
            o_verdict.result_code = RC_MUTED;
            o_verdict.run_state   = RUN_MUTED;
        end else if (!n_seen) begin
            o_verdict.result_code = RC_EMPTY;
        end else if (n_alnum < i_min_voice) begin
            o_verdict.result_code = RC_LOW_VOICE;
        end else if (wl == 4'd0 || n_failed || n_wake_idx < wl) begin
            o_verdict.result_code = RC_WAKE_MISSING;
        end else if (!n_cmd_seen) begin
            o_verdict.result_code = RC_NO_COMMAND;
        end else begin
            o_verdict.command_offset = (off_ext > 32'(OFFSET_SAT)) ? OFFSET_SAT
                                                                   : off_ext[11:0];
            o_verdict.cmd_len        = (len_ext > 32'(LEN_SAT)) ? LEN_SAT : len_ext[12:0];
            if (!n_over) begin
                o_verdict.send_ok   = 1'b1;
                o_verdict.run_state = RUN_SENDING;
            end
        end
    end

    // Hold transcript state; drop it after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos       <= '0;
            r_seen      <= 1'b0;
            r_wake_idx  <= '0;
            r_failed    <= 1'b0;
            r_alnum     <= '0;
            r_cmd_seen  <= 1'b0;
            r_cmd_start <= '0;
            r_last_ns   <= '0;
            r_ended     <= 1'b0;
            r_over      <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_seen      <= n_seen;
            r_wake_idx  <= n_wake_idx;
            r_failed    <= n_failed;
            r_alnum     <= n_alnum;
            r_cmd_seen  <= n_cmd_seen;
            r_cmd_start <= n_cmd_start;
            r_last_ns   <= n_last_ns;
            r_ended     <= n_ended;
            r_over      <= n_over;
        end
    end

endmodule

`default_nettype wire

@@ rtl/wake_word_command_gate.sv @@
`default_nettype none

// Wake-word command gate. Transcript bytes enter one per clock through push/full and
// the block sustains one byte every cycle while no stall holds it; the rate is set by
// the state update in the back end, which takes one classified byte per clock from a
// two-word queue fed by the classifier. A verdict word appears on the result side in
// the cycle after the back end takes the byte marked last, and waits there in a
// two-word queue until popped; bytes keep flowing while it waits, and the back end
// stalls only when it must place a new verdict into a full result queue. A NUL byte
// ends the text; later bytes up to the last one are ignored. Configuration writes
// take effect on the next clock and are to be made only while no transcript is in
// flight. No clearing pass follows reset.
module wake_word_command_gate #(
    parameter int MAX_LEN  = wwcg_pkg::MAX_LEN_DEF,
    parameter int WAKE_MAX = wwcg_pkg::WAKE_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [7:0]                      i_ch,
    input  wire logic                            i_last,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [2:0]                           o_result_code,
    output logic                                 o_should_send,
    output logic [11:0]                          o_command_offset,
    output logic [12:0]                          o_command_len,
    output logic [1:0]                           o_run_state,
    output logic                                 o_too_long,
    input  wire logic                            i_cfg_we,
    input  wire logic [wwcg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wwcg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wwcg_pkg::*;

    localparam int MID_W = $bits(t_cls) + WAKE_MAX;
    localparam int OUT_W = $bits(t_verdict);

    logic                    r_mute;
    logic [WAKE_CHARS_W-1:0] r_wake_chars;
    logic [3:0]              r_wake_len;
    logic [7:0]              r_min_voice;

    t_cls                    f_cls;
    logic [WAKE_MAX-1:0]     f_match;
    logic [MID_W-1:0]        mid_rdata;
    logic                    mid_empty;
    t_cls                    b_cls;
    logic [WAKE_MAX-1:0]     b_match;
    logic                    b_pop;
    logic                    b_push;
    t_verdict                b_verdict;
    logic                    out_full;
    logic [OUT_W-1:0]        out_rdata;
    t_verdict                res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mute       <= 1'b0;
            r_wake_chars <= '0;
            r_wake_len   <= '0;
            r_min_voice  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MUTE:       r_mute       <= i_cfg_data[0];
                CFG_WAKE_CHARS: r_wake_chars <= i_cfg_data[WAKE_CHARS_W-1:0];
                CFG_WAKE_LEN:   r_wake_len   <= i_cfg_data[3:0];
                CFG_MIN_VOICE:  r_min_voice  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    wwcg_front #(
        .WAKE_MAX (WAKE_MAX)
    ) u_front (
        .i_ch         (i_ch),
        .i_last       (i_last),
        .i_wake_chars (r_wake_chars),
        .o_cls        (f_cls),
        .o_match      (f_match)
    );

    wwcg_fifo #(
        .W     (MID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata ({f_cls, f_match}),
        .o_full  (full),
        .i_rd    (b_pop),
        .o_rdata (mid_rdata),
        .o_empty (mid_empty)
    );

    assign b_cls   = t_cls'(mid_rdata[MID_W-1 -: $bits(t_cls)]);
    assign b_match = mid_rdata[WAKE_MAX-1:0];

    wwcg_back #(
        .MAX_LEN  (MAX_LEN),
        .WAKE_MAX (WAKE_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mute      (r_mute),
        .i_wake_len  (r_wake_len),
        .i_min_voice (r_min_voice),
        .i_in_empty  (mid_empty),
        .i_cls       (b_cls),
        .i_match     (b_match),
        .o_pop       (b_pop),
        .i_out_full  (out_full),
        .o_push      (b_push),
        .o_verdict   (b_verdict)
    );

    wwcg_fifo #(
        .W     (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (b_push),
        .i_wdata (b_verdict),
        .o_full  (out_full),
        .i_rd    (pop),
        .o_rdata (out_rdata),
        .o_empty (empty)
    );

    // Unpack the oldest verdict word
    assign res              = t_verdict'(out_rdata);
    assign o_result_code    = res.result_code;
    assign o_should_send    = res.send_ok;
    assign o_command_offset = res.command_offset;
    assign o_command_len    = res.cmd_len;
    assign o_run_state      = res.run_state;
    assign o_too_long       = res.too_long;

endmodule

`default_nettype wire

@@ sim/wake_word_command_gate_test.sv @@
`timescale 1ns / 100ps

import wwcg_pkg::*;

// Tracks one transcript at a time, predicts its verdict word and checks
// the words that come back against the oldest prediction.
class verdict_ledger;
    bit        mute_on;
    bit [63:0] wake_chars;
    bit [3:0]  wake_count;
    bit [7:0]  min_voice;

    bit [12:0] byte_pos;
    bit        seen_text;
    bit [3:0]  wake_idx;
    bit        wake_failed;
    bit [7:0]  alnum_cnt;
    bit        cmd_seen;
    bit [11:0] cmd_start;
    bit [11:0] last_solid;
    bit        text_ended;
    bit        overflowed;

    t_verdict  awaited_verdicts[$];
    int        mismatches;

    function void set_reg(t_cfg_idx idx, bit [63:0] val);
        case (idx)
            CFG_MUTE:       mute_on    = val[0];
            CFG_WAKE_CHARS: wake_chars = val;
            CFG_WAKE_LEN:   wake_count = val[3:0];
            CFG_MIN_VOICE:  min_voice  = val[7:0];
            default: ;
        endcase
    endfunction

    // Lengths above the wake word storage act as a full-length wake word
    function int wake_span();
        return (wake_count > WAKE_MAX_DEF) ? WAKE_MAX_DEF : wake_count;
    endfunction

    function bit is_blank(bit [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit is_word_char(bit [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function bit [7:0] fold_case(bit [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c | 8'h20 : c;
    endfunction

    function void clear_text();
        byte_pos    = '0;
        seen_text   = 1'b0;
        wake_idx    = '0;
        wake_failed = 1'b0;
        alnum_cnt   = '0;
        cmd_seen    = 1'b0;
        cmd_start   = '0;
        last_solid  = '0;
        text_ended  = 1'b0;
        overflowed  = 1'b0;
    endfunction

    // Advance the transcript state by one text byte
    function void take_char(bit [7:0] c);
        bit [11:0] here;
        bit        blank;
        bit [7:0]  want;
        if (byte_pos >= MAX_LEN_DEF) begin
            overflowed = 1'b1;
            return;
        end
        here     = byte_pos[11:0];
        byte_pos = byte_pos + 13'd1;
        blank    = is_blank(c);
        if (!seen_text && blank)
            return;
        seen_text = 1'b1;
        if (is_word_char(c) && alnum_cnt != 8'hFF)
            alnum_cnt = alnum_cnt + 8'd1;
        if (!blank)
            last_solid = here;
        if (wake_span() == 0 || wake_failed)
            return;
        if (wake_idx < wake_span()) begin
            want = wake_chars[8 * wake_idx[2:0] +: 8];
            if (fold_case(c) == fold_case(want))
                wake_idx = wake_idx + 4'd1;
            else
                wake_failed = 1'b1;
            return;
        end
        if (!cmd_seen && !blank) begin
            cmd_seen  = 1'b1;
            cmd_start = here;
        end
    endfunction

    // Note one accepted input word; the final byte yields a predicted verdict
    function void note_byte(bit [7:0] c, bit fin);
        t_verdict v;
        if (!text_ended) begin
            if (c == 8'd0)
                text_ended = 1'b1;
            else
                take_char(c);
        end
        if (!fin)
            return;
        v = '0;
        v.too_long = overflowed;
        if (mute_on) begin
            v.result_code = RC_MUTED;
            v.run_state   = RUN_MUTED;
        end else if (!seen_text) begin
            v.result_code = RC_EMPTY;
        end else if (alnum_cnt < min_voice) begin
            v.result_code = RC_LOW_VOICE;
        end else if (wake_span() == 0 || wake_failed || wake_idx < wake_span()) begin
            v.result_code = RC_WAKE_MISSING;
        end else if (!cmd_seen) begin
            v.result_code = RC_NO_COMMAND;
        end else begin
            v.result_code    = RC_ACCEPTED;
            v.command_offset = cmd_start;
            v.cmd_len        = {1'b0, last_solid} - {1'b0, cmd_start} + 13'd1;
            if (!overflowed) begin
                v.send_ok   = 1'b1;
                v.run_state = RUN_SENDING;
            end
        end
        awaited_verdicts.push_back(v);
        clear_text();
    endfunction

    task flag_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Compare a popped verdict word field by field with the oldest prediction
    task check_verdict(t_verdict got);
        t_verdict want;
        if (awaited_verdicts.size() == 0) begin
            flag_mismatch($sformatf("verdict word with none awaited, code %0d",
                                    got.result_code));
            return;
        end
        want = awaited_verdicts.pop_front();
        if (got.result_code !== want.result_code)
            flag_mismatch($sformatf("result_code got %0d want %0d",
                                    got.result_code, want.result_code));
        if (got.send_ok !== want.send_ok)
            flag_mismatch($sformatf("send flag got %0d want %0d",
                                    got.send_ok, want.send_ok));
        if (got.command_offset !== want.command_offset)
            flag_mismatch($sformatf("command_offset got %0d want %0d",
                                    got.command_offset, want.command_offset));
        if (got.cmd_len !== want.cmd_len)
            flag_mismatch($sformatf("command length got %0d want %0d",
                                    got.cmd_len, want.cmd_len));
        if (got.run_state !== want.run_state)
            flag_mismatch($sformatf("run_state got %0d want %0d",
                                    got.run_state, want.run_state));
        if (got.too_long !== want.too_long)
            flag_mismatch($sformatf("too_long got %0d want %0d",
                                    got.too_long, want.too_long));
    endtask
endclass

module wake_word_command_gate_test;

    localparam int        RESULT_HOLD  = 300;
    localparam int        QUIET_LIMIT  = 3000;
    localparam int        RANDOM_BYTES = 1550;
    // "hey", first letter in the lowest byte
    localparam bit [63:0] HEY_WORD     = 64'h0000_0000_0079_6568;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic [7:0]            i_ch;
    logic                  i_last;
    logic                  empty;
    logic                  pop;
    logic [2:0]            o_result_code;
    logic                  o_should_send;
    logic [11:0]           o_command_offset;
    logic [12:0]           o_command_len;
    logic [1:0]            o_run_state;
    logic                  o_too_long;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    verdict_ledger board;
    bit [7:0]      script[$];
    bit            calm;
    bit            hold_results;
    int            sent_bytes;
    int            quiet_cycles;

    wake_word_command_gate dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_ch             (i_ch),
        .i_last           (i_last),
        .empty            (empty),
        .pop              (pop),
        .o_result_code    (o_result_code),
        .o_should_send    (o_should_send),
        .o_command_offset (o_command_offset),
        .o_command_len    (o_command_len),
        .o_run_state      (o_run_state),
        .o_too_long       (o_too_long),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // End the run when no word moves on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic bit [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 255);
        return pick[7:0];
    endfunction

    function automatic bit [7:0] rand_blank();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? 8'd32 : 8'd9 + pick[7:0];
    endfunction

    function automatic bit [7:0] rand_text_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            pick = $urandom_range(8'h61, 8'h7A);
        else if (pick < 5)
            pick = $urandom_range(8'h41, 8'h5A);
        else if (pick < 7)
            pick = $urandom_range(8'h30, 8'h39);
        else if (pick < 9)
            pick = $urandom_range(33, 126);
        else
            pick = $urandom_range(128, 255);
        return pick[7:0];
    endfunction

    function automatic bit [7:0] rand_wake_char();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            pick = $urandom_range(8'h61, 8'h7A);
        else if (pick < 6)
            pick = $urandom_range(8'h41, 8'h5A);
        else if (pick < 8)
            pick = $urandom_range(8'h30, 8'h39);
        else
            pick = $urandom_range(1, 255);
        return pick[7:0];
    endfunction

    // Build one random transcript: mostly wake word plus command, some broken, some noise
    function automatic void compose();
        int       kind;
        int       span;
        int       stop;
        int       bad;
        int       count;
        bit [7:0] c;
        script.delete();
        span = board.wake_span();
        kind = $urandom_range(0, 99);
        if (kind >= 85) begin
            count = $urandom_range(1, 12);
            repeat (count) begin
                c = (kind >= 95) ? rand_blank() : rand_byte();
                script.push_back(c);
            end
            return;
        end
        repeat ($urandom_range(0, 3)) script.push_back(rand_blank());
        stop = span;
        bad  = WAKE_MAX_DEF;
        if (kind >= 78)
            bad = $urandom_range(0, WAKE_MAX_DEF - 1);
        else if (kind >= 70 && span > 0)
            stop = $urandom_range(0, span - 1);
        for (int i = 0; i < stop; i++) begin
            c = board.wake_chars[8 * i +: 8];
            if (i == bad)
                c = c ^ rand_byte();
            else if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A && $urandom_range(0, 1))
                c = c ^ 8'h20;
            script.push_back(c);
        end
        if (stop == span) begin
            repeat ($urandom_range(0, 2)) script.push_back(rand_blank());
            if (board.min_voice >= 200 && $urandom_range(0, 1))
                count = $urandom_range(250, 300);
            else
                count = $urandom_range(0, 10);
            repeat (count) begin
                c = ($urandom_range(0, 5) == 0) ? rand_blank() : rand_text_char();
                script.push_back(c);
            end
            repeat ($urandom_range(0, 3)) script.push_back(rand_blank());
        end
        // end the text early with a NUL and some junk after it
        if ($urandom_range(0, 5) == 0) begin
            script.push_back(8'd0);
            repeat ($urandom_range(0, 3)) begin
                c = rand_byte();
                script.push_back(c);
            end
        end
        if (script.size() == 0)
            script.push_back(rand_blank());
    endfunction

    // Offer one byte, idling at random first, and hold it until taken
    task automatic offer_byte(input bit [7:0] c, input bit fin);
        if (!calm && $urandom_range(0, 99) < 9) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_ch   <= c;
        i_last <= fin;
        do
            @(posedge i_clk);
        while (full);
        board.note_byte(c, fin);
    endtask

    task automatic send_script();
        for (int i = 0; i < script.size(); i++)
            offer_byte(script[i], i == script.size() - 1);
        sent_bytes += script.size();
    endtask

    task automatic say(input string s);
        script.delete();
        for (int i = 0; i < s.len(); i++)
            script.push_back(s[i]);
        send_script();
    endtask

    // Drop push and drain every awaited verdict before touching registers
    task automatic settle();
        push <= 1'b0;
        while (board.awaited_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input bit [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.set_reg(idx, val);
    endtask

    task automatic apply_settings(input bit m, input bit [63:0] chars,
                                  input bit [3:0] wl, input bit [7:0] mv);
        write_reg(CFG_MUTE, {63'd0, m});
        write_reg(CFG_WAKE_CHARS, chars);
        write_reg(CFG_WAKE_LEN, {60'd0, wl});
        write_reg(CFG_MIN_VOICE, {56'd0, mv});
        i_cfg_we <= 1'b0;
    endtask

    task automatic pick_settings();
        bit [63:0] chars;
        int        pick;
        int        wl;
        int        mv;
        for (int i = 0; i < 8; i++)
            chars[8 * i +: 8] = rand_wake_char();
        pick = $urandom_range(0, 9);
        if (pick == 0)
            chars = '0;
        else if (pick == 1)
            chars = '1;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            wl = 0;
        else if (pick == 1)
            wl = $urandom_range(9, 15);
        else
            wl = $urandom_range(1, 8);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            mv = 255;
        else if (pick == 1)
            mv = $urandom_range(0, 255);
        else
            mv = $urandom_range(0, 6);
        apply_settings($urandom_range(0, 7) == 0, chars, wl[3:0], mv[7:0]);
    endtask

    // Pop verdict words, idling at random, with one long hold-off on request
    initial begin : result_side
        t_verdict seen;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_results) begin
                pop <= 1'b0;
                repeat (RESULT_HOLD) @(posedge i_clk);
                hold_results = 1'b0;
            end
            pop <= calm || ($urandom_range(0, 99) >= 9);
            @(posedge i_clk);
            if (pop && !empty) begin
                seen.result_code    = t_result_code'(o_result_code);
                seen.send_ok        = o_should_send;
                seen.command_offset = o_command_offset;
                seen.cmd_len        = o_command_len;
                seen.run_state      = t_run_state'(o_run_state);
                seen.too_long       = o_too_long;
                board.check_verdict(seen);
            end
        end
    end

    initial begin : byte_side
        int phase;
        int goal;
        board        = new();
        calm         = 1'b0;
        hold_results = 1'b0;
        sent_bytes   = 0;
        quiet_cycles = 0;
        i_rst_n    <= 1'b0;
        push       <= 1'b0;
        i_ch       <= 8'd0;
        i_last     <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_MUTE;
        i_cfg_data <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: an empty wake word never matches
        say("go");
        settle();
        apply_settings(1'b0, HEY_WORD, 4'd3, 8'd2);
        say(" ");
        say("\tHEY go \n");
        say("hey");
        say("heyx");
        say("he");
        say("hi");
        say("!!");
        // NUL ends the text, junk after it is dropped
        script.delete();
        for (int i = 0; i < 5; i++)
            script.push_back(i < 3 ? HEY_WORD[8 * i +: 8] : (i == 3 ? 8'd32 : 8'h61));
        script.push_back(8'd0);
        script.push_back(8'hFF);
        send_script();
        script.delete();
        script.push_back(8'd0);
        send_script();
        settle();
        apply_settings(1'b1, HEY_WORD, 4'd3, 8'd2);
        say("hey run");
        settle();
        // oversized wake length acts as eight characters
        apply_settings(1'b0, '1, 4'd15, 8'd255);
        say("hey");
        settle();
        apply_settings(1'b0, '1, 4'd15, 8'd0);
        script.delete();
        repeat (8) script.push_back(8'hFF);
        script.push_back(8'h7A);
        send_script();
        script.delete();
        repeat (7) script.push_back(8'hFF);
        script.push_back(8'h7A);
        send_script();
        settle();

        // back up the result side until the block stalls its input
        apply_settings(1'b0, HEY_WORD, 4'd3, 8'd1);
        calm         = 1'b1;
        hold_results = 1'b1;
        repeat (40) say("hey a");
        settle();
        calm = 1'b0;

        // random phases, each under fresh settings
        sent_bytes = 0;
        phase      = 0;
        while (sent_bytes < RANDOM_BYTES) begin
            pick_settings();
            calm = (phase == 3);
            goal = sent_bytes + $urandom_range(100, 200);
            while (sent_bytes < goal) begin
                compose();
                send_script();
            end
            settle();
            phase++;
        end
        calm = 1'b0;

        repeat (16) @(posedge i_clk);
        if (board.mismatches == 0 && board.awaited_verdicts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/wwcg_pkg.sv
rtl/wwcg_fifo.sv
rtl/wwcg_front.sv
rtl/wwcg_back.sv
rtl/wake_word_command_gate.sv
sim/wake_word_command_gate_test.sv
